// File: src/codel_pkg.sv
// Shared types and constants for the CoDel queue manager.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package codel_pkg;
    localparam int TIME_W = 64;
    localparam int TAG_W  = 16;
    localparam int LEN_W  = 16;
    localparam int BKLG_W = 22;
    localparam int CNT_W  = 16;

    typedef enum logic [2:0] {
        OC_ACCEPTED = 3'd0,
        OC_REJECTED = 3'd1,
        OC_DELIVERED = 3'd2,
        OC_DROPPED = 3'd3,
        OC_EMPTY = 3'd4
    } outcome_t;

    localparam logic [1:0] REG_TARGET   = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_MTU      = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [BKLG_W-1:0] BKLG_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
endpackage
`default_nettype wire

// File: src/codel_queue_manager_unit.sv
// CoDel queue manager top level: packet FIFO, drop state and sequencer.
// Shared iterative divider / square-root unit. Depends on codel_pkg.
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | ports
// s_      | in        | s_valid s_ready s_operation s_now_time s_packet_length s_packet_tag
// m_      | out       | m_valid m_ready m_outcome m_out_tag m_out_length m_last_result
// cfg     | in        | cfg_we cfg_index cfg_data
// Enqueue steps: accept, result. Dequeue without a drop: accept, read, measure,
// decide, result, settle. Each further pop passes through read and measure again;
// each control-law step runs a 65-step restoring divide, a 33-step root and an update
// on one shared shift/subtract unit. s_ready is low while an item is in progress.
// A stalled m_ready holds the sequencer.
// Synchronous active-low reset clears pointers and drop state; store contents
// are not cleared.
module codel_queue_manager_unit #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [63:0] s_now_time,
    input  wire logic [15:0] s_packet_length,
    input  wire logic [15:0] s_packet_tag,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_outcome,
    output logic [15:0]      m_out_tag,
    output logic [15:0]      m_out_length,
    output logic             m_last_result
);
    import codel_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OW-1:0] DEPTH_C = OW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_IDX = PW'(QUEUE_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_ENQ, ST_POP_RD, ST_POP_EVAL, ST_DECIDE, ST_LOOP,
        ST_LAW_DIV, ST_LAW_SQRT, ST_LAW_DONE, ST_EMIT, ST_WAIT
    } state_t;

    typedef enum logic [1:0] {
        AFT_LOOP, AFT_FIRST, AFT_FINAL
    } after_t;

    logic [TAG_W-1:0]  tag_mem [QUEUE_DEPTH];
    logic [LEN_W-1:0]  len_mem [QUEUE_DEPTH];
    logic [TIME_W-1:0] arr_mem [QUEUE_DEPTH];

    state_t state_reg;
    after_t after_reg;
    logic [PW-1:0] head_reg, tail_reg;
    logic [OW-1:0] occ_reg;
    logic [BKLG_W-1:0] bklg_reg;
    logic drop_mode_reg;
    logic [TIME_W-1:0] bad_end_reg, next_drop_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_prior_reg;
    logic [31:0] target_reg, interval_reg;
    logic [15:0] mtu_reg;

    logic [TIME_W-1:0] now_reg;
    logic [LEN_W-1:0] in_len_reg;
    logic [TAG_W-1:0] in_tag_reg;

    logic [TAG_W-1:0] rd_tag_reg;
    logic [LEN_W-1:0] rd_len_reg;
    logic [TIME_W-1:0] rd_arr_reg;
    logic have_reg, ok_reg;
    logic [6:0] nres_reg;
    logic [TIME_W-1:0] law_base_reg;

    // shared iterative unit: restoring divide then bitwise square root
    logic [TIME_W-1:0] num_reg, quo_reg, den_reg;
    logic [TIME_W:0]   rem_reg;
    logic [TIME_W-1:0] sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [6:0] step_reg;

    logic m_valid_reg, m_last_reg;
    logic [2:0] m_outcome_reg;
    logic [15:0] m_tag_reg, m_len_reg;

    logic [TIME_W:0] rem_sh, sub_val;
    logic [TIME_W-1:0] sq_trial, sojourn, sum_ni;
    logic sum_ni_c;
    logic [TIME_W:0] sat_tmp;
    logic [BKLG_W-1:0] bklg_dec;
    logic [TIME_W-1:0] law_sum;
    logic law_c;
    logic [CNT_W-1:0] delta;
    logic [TIME_W:0] recent_sum;
    logic [TIME_W-1:0] recent_lim;
    logic [TIME_W-1:0] iv_sq;
    logic pop_bad, pop_ok;
    logic m_free, loop_go, emit_now;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_outcome = m_outcome_reg;
    assign m_out_tag = m_tag_reg;
    assign m_out_length = m_len_reg;
    assign m_last_result = m_last_reg;

    always_comb begin
        rem_sh = {rem_reg[TIME_W-1:0], num_reg[TIME_W-1]};
        sub_val = rem_sh - {1'b0, den_reg};
        sq_trial = sq_r_reg + sq_bit_reg;
        sojourn = (now_reg >= rd_arr_reg) ? now_reg - rd_arr_reg : '0;
        sat_tmp = {1'b0, now_reg} + {33'd0, interval_reg};
        sum_ni = sat_tmp[TIME_W-1:0];
        sum_ni_c = sat_tmp[TIME_W];
        bklg_dec = (bklg_reg >= BKLG_W'(rd_len_reg)) ? bklg_reg - BKLG_W'(rd_len_reg) : '0;
        {law_c, law_sum} = {1'b0, law_base_reg} + {1'b0, sq_r_reg};
        delta = cnt_reg - cnt_prior_reg;
        recent_sum = {1'b0, next_drop_reg} + {29'd0, interval_reg, 4'd0};
        recent_lim = recent_sum[TIME_W] ? TIME_MAX : recent_sum[TIME_W-1:0];
        iv_sq = 64'(interval_reg) * 64'(interval_reg);
        pop_bad = !(sojourn < 64'(target_reg) || bklg_dec < BKLG_W'(mtu_reg));
        pop_ok = (occ_reg != '0) && pop_bad && (bad_end_reg != '0)
                 && (now_reg >= bad_end_reg);
        m_free = !m_valid_reg || m_ready;
        loop_go = have_reg && drop_mode_reg && (now_reg >= next_drop_reg)
                  && (nres_reg < 7'd63);
        emit_now = m_free && ((state_reg == ST_ENQ) || (state_reg == ST_EMIT)
                   || (state_reg == ST_DECIDE && have_reg && !drop_mode_reg && ok_reg)
                   || (state_reg == ST_LOOP && loop_go));
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ENQ && occ_reg < DEPTH_C) begin
            tag_mem[tail_reg] <= in_tag_reg;
            len_mem[tail_reg] <= in_len_reg;
            arr_mem[tail_reg] <= now_reg;
        end
        if (state_reg == ST_POP_RD) begin
            rd_tag_reg <= tag_mem[head_reg];
            rd_len_reg <= len_mem[head_reg];
            rd_arr_reg <= arr_mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            after_reg <= AFT_LOOP;
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg <= '0;
            bklg_reg <= '0;
            drop_mode_reg <= 1'b0;
            bad_end_reg <= '0;
            next_drop_reg <= '0;
            cnt_reg <= '0;
            cnt_prior_reg <= '0;
            target_reg <= 32'd10000000;
            interval_reg <= 32'd100000000;
            mtu_reg <= 16'd1500;
            m_valid_reg <= 1'b0;
            have_reg <= 1'b0;
            ok_reg <= 1'b0;
            nres_reg <= '0;
            step_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TARGET:   target_reg <= cfg_data;
                    REG_INTERVAL: interval_reg <= cfg_data;
                    REG_MTU:      mtu_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_ready && !emit_now) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        now_reg <= s_now_time;
                        in_len_reg <= s_packet_length;
                        in_tag_reg <= s_packet_tag;
                        nres_reg <= '0;
                        state_reg <= s_operation ? ST_POP_RD : ST_ENQ;
                    end
                end
                ST_ENQ: begin
                    if (m_free) begin
                        m_valid_reg <= 1'b1;
                        m_tag_reg <= '0;
                        m_len_reg <= '0;
                        m_last_reg <= 1'b1;
                        if (occ_reg >= DEPTH_C) begin
                            m_outcome_reg <= OC_REJECTED;
                        end else begin
                            m_outcome_reg <= OC_ACCEPTED;
                            tail_reg <= (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                            occ_reg <= occ_reg + 1'b1;
                            if ({1'b0, bklg_reg} + (BKLG_W+1)'(in_len_reg) > (BKLG_W+1)'(BKLG_MAX))
                                bklg_reg <= BKLG_MAX;
                            else
                                bklg_reg <= bklg_reg + BKLG_W'(in_len_reg);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_POP_RD: begin
                    // read data registers this cycle
                    state_reg <= ST_POP_EVAL;
                end
                ST_POP_EVAL: begin
                    ok_reg <= pop_ok;
                    if (occ_reg == '0) begin
                        bad_end_reg <= '0;
                        have_reg <= 1'b0;
                    end else begin
                        have_reg <= 1'b1;
                        head_reg <= (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                        occ_reg <= occ_reg - 1'b1;
                        bklg_reg <= bklg_dec;
                        if (!pop_bad)
                            bad_end_reg <= '0;
                        else if (bad_end_reg == '0)
                            bad_end_reg <= sum_ni_c ? TIME_MAX : sum_ni;
                    end
                    case (after_reg)
                        AFT_LOOP: begin
                            if (nres_reg == '0) begin
                                state_reg <= ST_DECIDE;
                            end else if (pop_ok) begin
                                law_base_reg <= next_drop_reg;
                                state_reg <= ST_LAW_DIV;
                            end else begin
                                drop_mode_reg <= 1'b0;
                                state_reg <= ST_LOOP;
                            end
                        end
                        AFT_FIRST: begin
                            drop_mode_reg <= 1'b1;
                            law_base_reg <= now_reg;
                            if (now_reg < recent_lim && delta > 16'd1) begin
                                cnt_reg <= delta;
                                cnt_prior_reg <= delta;
                            end else begin
                                cnt_reg <= 16'd1;
                                cnt_prior_reg <= 16'd1;
                            end
                            after_reg <= AFT_FINAL;
                            state_reg <= ST_LAW_DIV;
                        end
                        default: state_reg <= ST_EMIT;
                    endcase
                end
                ST_DECIDE: begin
                    if (!have_reg) begin
                        drop_mode_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                    end else if (drop_mode_reg) begin
                        if (!ok_reg) drop_mode_reg <= 1'b0;
                        state_reg <= ST_LOOP;
                    end else if (ok_reg) begin
                        if (m_free) begin
                            m_valid_reg <= 1'b1;
                            m_outcome_reg <= OC_DROPPED;
                            m_tag_reg <= rd_tag_reg;
                            m_len_reg <= rd_len_reg;
                            m_last_reg <= 1'b0;
                            nres_reg <= nres_reg + 1'b1;
                            after_reg <= AFT_FIRST;
                            state_reg <= ST_POP_RD;
                        end
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_LOOP: begin
                    if (loop_go) begin
                        if (m_free) begin
                            m_valid_reg <= 1'b1;
                            m_outcome_reg <= OC_DROPPED;
                            m_tag_reg <= rd_tag_reg;
                            m_len_reg <= rd_len_reg;
                            m_last_reg <= 1'b0;
                            nres_reg <= nres_reg + 1'b1;
                            if (cnt_reg != CNT_MAX) cnt_reg <= cnt_reg + 1'b1;
                            after_reg <= AFT_LOOP;
                            state_reg <= ST_POP_RD;
                        end
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_LAW_DIV: begin
                    if (step_reg == '0) begin
                        num_reg <= iv_sq;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        den_reg <= (cnt_reg == '0) ? 64'd1 : 64'(cnt_reg);
                        step_reg <= 7'd1;
                    end else begin
                        num_reg <= num_reg << 1;
                        if (!sub_val[TIME_W]) begin
                            rem_reg <= sub_val;
                            quo_reg <= {quo_reg[TIME_W-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[TIME_W-2:0], 1'b0};
                        end
                        if (step_reg == 7'd64) begin
                            step_reg <= '0;
                            state_reg <= ST_LAW_SQRT;
                        end else begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                ST_LAW_SQRT: begin
                    if (step_reg == '0) begin
                        sq_v_reg <= quo_reg;
                        sq_r_reg <= '0;
                        sq_bit_reg <= 64'd1 << 62;
                        step_reg <= 7'd1;
                    end else begin
                        if (sq_v_reg >= sq_trial) begin
                            sq_v_reg <= sq_v_reg - sq_trial;
                            sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                        end else begin
                            sq_r_reg <= sq_r_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                        if (step_reg == 7'd32) begin
                            step_reg <= '0;
                            state_reg <= ST_LAW_DONE;
                        end else begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                end
                ST_LAW_DONE: begin
                    next_drop_reg <= law_c ? TIME_MAX : law_sum;
                    state_reg <= (after_reg == AFT_LOOP) ? ST_LOOP : ST_EMIT;
                end
                ST_EMIT: begin
                    if (m_free) begin
                        m_valid_reg <= 1'b1;
                        m_last_reg <= 1'b1;
                        if (have_reg) begin
                            m_outcome_reg <= OC_DELIVERED;
                            m_tag_reg <= rd_tag_reg;
                            m_len_reg <= rd_len_reg;
                        end else begin
                            m_outcome_reg <= OC_EMPTY;
                            m_tag_reg <= '0;
                            m_len_reg <= '0;
                        end
                        after_reg <= AFT_LOOP;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for codel_queue_manager_unit: an in-bench CoDel predictor
// with directed scenarios, configuration sweeps, random traffic and output stalls.
// Depends on codel_pkg and codel_queue_manager_unit.
`timescale 1ns / 1ps
module testbench;
    import codel_pkg::*;

    localparam int DEPTH = 64;
    localparam int MAX_OUT = 64;
    localparam int IDLE_LIMIT = 60000;

    typedef struct packed {
        outcome_t    oc;
        logic [15:0] tag;
        logic [15:0] len;
        logic        last;
    } word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [63:0] s_now_time;
    logic [15:0] s_packet_length;
    logic [15:0] s_packet_tag;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_outcome;
    logic [15:0] m_out_tag;
    logic [15:0] m_out_length;
    logic        m_last_result;

    codel_queue_manager_unit #(.QUEUE_DEPTH(DEPTH)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_now_time(s_now_time), .s_packet_length(s_packet_length),
        .s_packet_tag(s_packet_tag),
        .m_valid(m_valid), .m_ready(m_ready), .m_outcome(m_outcome),
        .m_out_tag(m_out_tag), .m_out_length(m_out_length),
        .m_last_result(m_last_result)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // queue model state
    logic [15:0]  tag_mem [DEPTH];
    logic [15:0]  len_mem [DEPTH];
    logic [63:0]  arr_mem [DEPTH];
    logic [5:0]   hd, tl;
    int           q_count;
    logic [21:0]  backlog;
    bit           dropping;
    logic [63:0]  bad_end;
    logic [63:0]  next_drop;
    logic [15:0]  drop_cnt;
    logic [15:0]  drop_cnt_prior;
    logic [31:0]  target_ns;
    logic [31:0]  interval_ns;
    logic [15:0]  mtu;

    word_t       pending_words[$];
    int          errors = 0;
    int          items_sent = 0;
    int          words_seen = 0;
    int          drops_seen = 0;
    int          rejects_seen = 0;
    int          idle_cycles = 0;
    int          hold_pending = 0;
    bit          no_idle = 0;
    logic [63:0] now_ns = 0;

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? TIME_MAX : s;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] next_drop_at(input logic [15:0] cnt,
                                                 input logic [63:0] last);
        logic [63:0] iv, c;
        iv = {32'b0, interval_ns};
        c = (cnt == 0) ? 64'd1 : {48'b0, cnt};
        return add_sat(last, root64((iv * iv) / c));
    endfunction

    function automatic bit pop_head(input logic [63:0] now, output logic [15:0] t,
                                    output logic [15:0] l, output bit ok);
        logic [63:0] ts, soj;
        ok = 0;
        t = 0;
        l = 0;
        if (q_count == 0) begin
            bad_end = 0;
            return 0;
        end
        t = tag_mem[hd];
        l = len_mem[hd];
        ts = arr_mem[hd];
        hd = hd + 6'd1;
        q_count--;
        backlog = (backlog >= {6'b0, l}) ? backlog - {6'b0, l} : 22'd0;
        soj = (now >= ts) ? now - ts : 0;
        if (soj < {32'b0, target_ns} || backlog < {6'b0, mtu})
            bad_end = 0;
        else if (bad_end == 0)
            bad_end = add_sat(now, {32'b0, interval_ns});
        else if (now >= bad_end)
            ok = 1;
        return 1;
    endfunction

    function automatic void push_word(input outcome_t oc, input logic [15:0] t,
                                      input logic [15:0] l, input logic last);
        word_t w;
        w.oc = oc;
        w.tag = t;
        w.len = l;
        w.last = last;
        pending_words.push_back(w);
    endfunction

    function automatic void predict_queue(input logic op, input logic [63:0] now,
                                          input logic [15:0] l_in, input logic [15:0] t_in);
        logic [15:0] t, l, delta;
        bit ok, have, recent;
        int n;
        t = 0;
        l = 0;
        n = 0;
        if (op == 1'b0) begin
            if (q_count >= DEPTH) begin
                push_word(OC_REJECTED, 16'd0, 16'd0, 1'b1);
                return;
            end
            tag_mem[tl] = t_in;
            len_mem[tl] = l_in;
            arr_mem[tl] = now;
            tl = tl + 6'd1;
            q_count++;
            backlog = ({1'b0, backlog} + {7'b0, l_in} > {1'b0, BKLG_MAX}) ? BKLG_MAX
                      : backlog + {6'b0, l_in};
            push_word(OC_ACCEPTED, 16'd0, 16'd0, 1'b1);
            return;
        end
        have = pop_head(now, t, l, ok);
        if (!have) begin
            dropping = 0;
            push_word(OC_EMPTY, 16'd0, 16'd0, 1'b1);
            return;
        end
        if (dropping) begin
            if (!ok) dropping = 0;
            while (have && dropping && now >= next_drop && n < MAX_OUT - 1) begin
                push_word(OC_DROPPED, t, l, 1'b0);
                n++;
                if (drop_cnt != CNT_MAX) drop_cnt = drop_cnt + 16'd1;
                have = pop_head(now, t, l, ok);
                if (ok) next_drop = next_drop_at(drop_cnt, next_drop);
                else dropping = 0;
            end
        end else if (ok) begin
            push_word(OC_DROPPED, t, l, 1'b0);
            have = pop_head(now, t, l, ok);
            dropping = 1;
            delta = drop_cnt - drop_cnt_prior;
            drop_cnt = 16'd1;
            recent = now < add_sat(next_drop, 64'd16 * {32'b0, interval_ns});
            if (recent && delta > 16'd1) drop_cnt = delta;
            next_drop = next_drop_at(drop_cnt, now);
            drop_cnt_prior = drop_cnt;
        end
        if (have) push_word(OC_DELIVERED, t, l, 1'b1);
        else push_word(OC_EMPTY, 16'd0, 16'd0, 1'b1);
    endfunction

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(10, 40));
        return int'($urandom_range(1, 3));
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch word %0d: %s got %0h want %0h", words_seen, what, got, want);
        errors++;
    endtask

    task automatic send(input logic op, input logic [63:0] now,
                        input logic [15:0] l, input logic [15:0] t);
        int gap;
        s_valid <= 1'b1;
        s_operation <= op;
        s_now_time <= now;
        s_packet_length <= l;
        s_packet_tag <= t;
        do @(posedge aclk); while (!s_ready);
        predict_queue(op, now, l, t);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic enq(input logic [15:0] l, input logic [15:0] t);
        send(1'b0, now_ns, l, t);
    endtask

    task automatic deq();
        send(1'b1, now_ns, 16'($urandom), 16'($urandom));
    endtask

    task automatic drain_wait();
        @(posedge aclk);
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TARGET:   target_ns = val;
            REG_INTERVAL: interval_ns = val;
            REG_MTU:      mtu = val[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] tg, input logic [31:0] iv, input logic [15:0] m);
        drain_wait();
        write_reg(REG_TARGET, tg);
        write_reg(REG_INTERVAL, iv);
        write_reg(REG_MTU, {16'b0, m});
    endtask

    // reset defaults: empty pops, field extremes, time running backwards
    task automatic test_basic();
        deq();
        enq(16'h0000, 16'hFFFF);
        enq(16'hFFFF, 16'h0000);
        enq(16'h5A5A, 16'hA5A5);
        now_ns = now_ns + 64'd20000000;
        deq();
        send(1'b1, 64'd0, 16'h0, 16'h0);
        deq();
        deq();
    endtask

    // full store rejects, then drain to empty
    task automatic test_full();
        for (int i = 0; i < DEPTH + 2; i++) begin
            now_ns = now_ns + 64'd1;
            enq(16'($urandom), 16'(i));
        end
        for (int i = 0; i < DEPTH + 1; i++) deq();
    endtask

    // standing delay: enter drop mode, hit the per-dequeue drop limit
    task automatic test_drop_burst();
        configure(32'd1, 32'd1, 16'd1);
        for (int i = 0; i < DEPTH; i++) enq(16'd1000, 16'(16'h100 + i));
        now_ns = now_ns + 64'd100;
        deq();
        now_ns = now_ns + 64'd100;
        deq();
        for (int i = 0; i < 3; i++) enq(16'd1000, 16'(16'h200 + i));
        now_ns = now_ns + 64'd100;
        deq();
        deq();
    endtask

    // time sums near the top of the range saturate
    task automatic test_time_limits();
        configure(32'd1, 32'hFFFF_FFFF, 16'd1);
        for (int i = 0; i < 4; i++) send(1'b0, TIME_MAX - 64'd100, 16'hFFFF, 16'(i));
        send(1'b1, TIME_MAX - 64'd10, 16'd0, 16'd0);
        send(1'b1, TIME_MAX, 16'd0, 16'd0);
        send(1'b1, TIME_MAX, 16'd0, 16'd0);
        send(1'b1, TIME_MAX, 16'd0, 16'd0);
        send(1'b1, TIME_MAX, 16'd0, 16'd0);
        now_ns = 64'd1000;
    endtask

    // receiver holds off while the sender keeps offering work
    task automatic test_backpressure();
        configure(32'd100, 32'd1000, 16'd1);
        hold_pending = 400;
        for (int i = 0; i < 12; i++) begin
            now_ns = now_ns + 64'd50;
            enq(16'($urandom), 16'($urandom));
        end
        for (int i = 0; i < 8; i++) begin
            now_ns = now_ns + 64'd300;
            deq();
        end
    endtask

    task automatic test_traffic(input int count, input int step_max);
        int done, k;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 9) < 8) begin
                k = int'($urandom_range(1, 20));
                if (2 * k + 1 > count - done) k = (count - done > 2) ? (count - done - 1) / 2 : 1;
                for (int i = 0; i < k; i++) begin
                    now_ns = now_ns + 64'($urandom_range(0, step_max / 4));
                    enq(16'($urandom), 16'($urandom));
                end
                for (int i = 0; i <= k; i++) begin
                    now_ns = now_ns + 64'($urandom_range(0, step_max));
                    deq();
                end
                done += 2 * k + 1;
            end else begin
                send(1'($urandom_range(0, 1)), {$urandom, $urandom}, 16'($urandom),
                     16'($urandom));
                done++;
            end
        end
    endtask

    task automatic test_config_sweep();
        configure(32'd100, 32'd1000, 16'd1);
        test_traffic(15, 300);
        configure(32'd0, 32'd0, 16'd0);
        test_traffic(10, 50);
        configure(32'd50, 32'd400, 16'd2000);
        test_traffic(15, 200);
        no_idle = 1;
        configure(32'd1, 32'd1, 16'd1);
        test_traffic(10, 5);
        no_idle = 0;
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        test_traffic(10, 1000);
        configure(32'd1000, 32'd5000, 16'd100);
        test_traffic(20, 2000);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_pending > 0) begin
            m_ready <= 1'b0;
            hold_pending--;
        end else begin
            m_ready <= (pick_gap() == 0);
        end
    end

    always @(posedge aclk) begin
        word_t w;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                report("unexpected word outcome", 16'(m_outcome), 16'd0);
            end else begin
                w = pending_words.pop_front();
                if (m_outcome != w.oc) report("outcome", 16'(m_outcome), 16'(w.oc));
                if (m_out_tag != w.tag) report("tag", m_out_tag, w.tag);
                if (m_out_length != w.len) report("length", m_out_length, w.len);
                if (m_last_result != w.last)
                    report("last", 16'(m_last_result), 16'(w.last));
                if (w.oc == OC_DROPPED) drops_seen++;
                if (w.oc == OC_REJECTED) rejects_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_operation <= 1'b0;
        s_now_time <= '0;
        s_packet_length <= '0;
        s_packet_tag <= '0;
        hd = 0;
        tl = 0;
        q_count = 0;
        backlog = 0;
        dropping = 0;
        bad_end = 0;
        next_drop = 0;
        drop_cnt = 0;
        drop_cnt_prior = 0;
        target_ns = 32'd10000000;
        interval_ns = 32'd100000000;
        mtu = 16'd1500;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic();
        test_full();
        test_drop_burst();
        test_time_limits();
        test_backpressure();
        test_config_sweep();
        drain_wait();
        repeat (50) @(posedge aclk);
        $display("covered %0d items, %0d result words, %0d drops, %0d full rejects",
                 items_sent, words_seen, drops_seen, rejects_seen);
        $display("config sweep included zero and all-ones target/interval/mtu settings");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// File: codel_queue_manager_unit.f
src/codel_pkg.sv
src/codel_queue_manager_unit.sv
test/testbench.sv
